// ===== design/arpr_pkg.sv =====
// Shared types, constants and reply byte builder for the ARP request responder.
package arpr_pkg;

    localparam int REPLY_LEN_DEF = 60;
    localparam int REPLY_LEN_MAX = 64;
    localparam int KIDX_W        = $clog2(REPLY_LEN_MAX);

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = MAC_W;
    localparam int IDX_W  = 6;

    localparam logic [IDX_W-1:0] ARP_MIN_LEN = 6'd42;

    localparam logic [IDX_W-1:0] IDX_HW_TYPE    = 6'd14;
    localparam logic [IDX_W-1:0] IDX_HW_TYPE_E  = 6'd15;
    localparam logic [IDX_W-1:0] IDX_PROTO      = 6'd16;
    localparam logic [IDX_W-1:0] IDX_PROTO_E    = 6'd17;
    localparam logic [IDX_W-1:0] IDX_HW_LEN     = 6'd18;
    localparam logic [IDX_W-1:0] IDX_PROTO_LEN  = 6'd19;
    localparam logic [IDX_W-1:0] IDX_OP         = 6'd20;
    localparam logic [IDX_W-1:0] IDX_OP_E       = 6'd21;
    localparam logic [IDX_W-1:0] IDX_SMAC       = 6'd22;
    localparam logic [IDX_W-1:0] IDX_SMAC_E     = 6'd27;
    localparam logic [IDX_W-1:0] IDX_SIP        = 6'd28;
    localparam logic [IDX_W-1:0] IDX_SIP_E      = 6'd31;
    localparam logic [IDX_W-1:0] IDX_TIP        = 6'd38;
    localparam logic [IDX_W-1:0] IDX_TIP_E      = 6'd41;

    localparam logic [15:0] HTYPE_ETHER    = 16'h0001;
    localparam logic [15:0] HTYPE_IEEE802  = 16'h0006;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_MAC       = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

    localparam logic [7:0] ARP_HDR [10] = '{
        8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
    };

    typedef enum logic [0:0] {
        CFG_OWN_IP  = 1'b0,
        CFG_OWN_MAC = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic             valid;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
    } t_reply_req;

    function automatic logic [BYTE_W-1:0] reply_byte(
        input logic [KIDX_W-1:0] k,
        input logic [MAC_W-1:0]  smac,
        input logic [IP_W-1:0]   sip,
        input logic [MAC_W-1:0]  omac,
        input logic [IP_W-1:0]   oip
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        priority if (k <= 6'd5) begin
            b = smac[8*(5 - int'(k)) +: 8];
        end else if (k <= 6'd11) begin
            b = omac[8*(11 - int'(k)) +: 8];
        end else if (k <= 6'd21) begin
            b = ARP_HDR[4'(k - 6'd12)];
        end else if (k <= 6'd27) begin
            b = omac[8*(27 - int'(k)) +: 8];
        end else if (k <= 6'd31) begin
            b = oip[8*(31 - int'(k)) +: 8];
        end else if (k <= 6'd37) begin
            b = smac[8*(37 - int'(k)) +: 8];
        end else if (k <= 6'd41) begin
            b = sip[8*(41 - int'(k)) +: 8];
        end else begin
            b = '0;
        end
        return b;
    endfunction

endpackage

// ===== design/arpr_parse.sv =====
// Receive side: byte position, ARP field capture and reply decision.
module arpr_parse (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [arpr_pkg::BYTE_W-1:0]    i_byte,
    input  logic                           i_last,
    input  logic [arpr_pkg::IP_W-1:0]      i_own_ip,
    input  logic                           i_gen_busy,
    output arpr_pkg::t_reply_req           o_req
);

    logic [arpr_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [15:0]                 r_hw_type, n_hw_type;
    logic [15:0]                 r_proto, n_proto;
    logic [7:0]                  r_hw_len, n_hw_len;
    logic [7:0]                  r_proto_len, n_proto_len;
    logic [15:0]                 r_op, n_op;
    logic [arpr_pkg::MAC_W-1:0]  r_smac, n_smac;
    logic [arpr_pkg::IP_W-1:0]   r_sip, n_sip;
    logic [arpr_pkg::IP_W-1:0]   r_tip, n_tip;
    logic                        r_eval, n_eval;
    logic                        r_len_ok, n_len_ok;
    logic                        accept;
    logic                        answer;
    logic                        load;

    assign answer = r_len_ok
                 && (r_hw_type == arpr_pkg::HTYPE_ETHER || r_hw_type == arpr_pkg::HTYPE_IEEE802)
                 && r_proto == arpr_pkg::PTYPE_IPV4
                 && r_hw_len == arpr_pkg::HLEN_MAC
                 && r_proto_len == arpr_pkg::PLEN_IPV4
                 && r_op == arpr_pkg::ARP_OP_REQUEST
                 && r_tip == i_own_ip;

    assign o_ready = !(r_eval && answer && i_gen_busy);
    assign accept  = i_valid && o_ready;
    assign load    = r_eval && answer && !i_gen_busy;

    assign o_req.valid      = load;
    assign o_req.sender_mac = r_smac;
    assign o_req.sender_ip  = r_sip;

    always_comb begin
        n_idx       = r_idx;
        n_hw_type   = r_hw_type;
        n_proto     = r_proto;
        n_hw_len    = r_hw_len;
        n_proto_len = r_proto_len;
        n_op        = r_op;
        n_smac      = r_smac;
        n_sip       = r_sip;
        n_tip       = r_tip;
        n_eval      = r_eval && answer && i_gen_busy;
        n_len_ok    = r_len_ok;
        if (accept) begin
            if (r_idx < arpr_pkg::ARP_MIN_LEN) begin
                n_idx = r_idx + 1'b1;
                priority if (r_idx >= arpr_pkg::IDX_HW_TYPE && r_idx <= arpr_pkg::IDX_HW_TYPE_E) begin
                    n_hw_type = {r_hw_type[7:0], i_byte};
                end else if (r_idx >= arpr_pkg::IDX_PROTO && r_idx <= arpr_pkg::IDX_PROTO_E) begin
                    n_proto = {r_proto[7:0], i_byte};
                end else if (r_idx == arpr_pkg::IDX_HW_LEN) begin
                    n_hw_len = i_byte;
                end else if (r_idx == arpr_pkg::IDX_PROTO_LEN) begin
                    n_proto_len = i_byte;
                end else if (r_idx >= arpr_pkg::IDX_OP && r_idx <= arpr_pkg::IDX_OP_E) begin
                    n_op = {r_op[7:0], i_byte};
                end else if (r_idx >= arpr_pkg::IDX_SMAC && r_idx <= arpr_pkg::IDX_SMAC_E) begin
                    n_smac = {r_smac[arpr_pkg::MAC_W-9:0], i_byte};
                end else if (r_idx >= arpr_pkg::IDX_SIP && r_idx <= arpr_pkg::IDX_SIP_E) begin
                    n_sip = {r_sip[arpr_pkg::IP_W-9:0], i_byte};
                end else if (r_idx >= arpr_pkg::IDX_TIP && r_idx <= arpr_pkg::IDX_TIP_E) begin
                    n_tip = {r_tip[arpr_pkg::IP_W-9:0], i_byte};
                end else begin
                    n_tip = r_tip;
                end
            end
            if (i_last) begin
                n_idx    = '0;
                n_eval   = 1'b1;
                n_len_ok = r_idx >= arpr_pkg::ARP_MIN_LEN - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_hw_type   <= '0;
            r_proto     <= '0;
            r_hw_len    <= '0;
            r_proto_len <= '0;
            r_op        <= '0;
            r_smac      <= '0;
            r_sip       <= '0;
            r_tip       <= '0;
            r_eval      <= 1'b0;
            r_len_ok    <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_hw_type   <= n_hw_type;
            r_proto     <= n_proto;
            r_hw_len    <= n_hw_len;
            r_proto_len <= n_proto_len;
            r_op        <= n_op;
            r_smac      <= n_smac;
            r_sip       <= n_sip;
            r_tip       <= n_tip;
            r_eval      <= n_eval;
            r_len_ok    <= n_len_ok;
        end
    end

    a_idx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= arpr_pkg::ARP_MIN_LEN)
        else $error("byte index past saturation");

    a_eval_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_eval) |-> $past(accept && i_last))
        else $error("decision raised without a last beat");

    a_req_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.valid |-> (r_proto == arpr_pkg::PTYPE_IPV4 && r_len_ok && !i_gen_busy))
        else $error("reply requested for a frame that does not qualify");

endmodule

// ===== design/arpr_reply.sv =====
// Transmit side: reply byte sequencer and output register.
module arpr_reply #(
    parameter int REPLY_LEN = arpr_pkg::REPLY_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arpr_pkg::t_reply_req           i_req,
    input  logic [arpr_pkg::MAC_W-1:0]     i_own_mac,
    input  logic [arpr_pkg::IP_W-1:0]      i_own_ip,
    output logic                           o_busy,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [arpr_pkg::BYTE_W-1:0]    o_byte,
    output logic                           o_last
);

    localparam int KW = $clog2(REPLY_LEN);
    localparam logic [KW-1:0] K_LAST = KW'(REPLY_LEN - 1);

    logic                          r_active, n_active;
    logic [KW-1:0]                 r_k, n_k;
    logic [arpr_pkg::MAC_W-1:0]    r_smac, n_smac;
    logic [arpr_pkg::IP_W-1:0]     r_sip, n_sip;
    logic                          r_out_valid, n_out_valid;
    logic [arpr_pkg::BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                          r_out_last, n_out_last;
    logic                          out_load;

    assign out_load = r_active && (!r_out_valid || i_ready);

    always_comb begin
        n_active    = r_active;
        n_k         = r_k;
        n_smac      = r_smac;
        n_sip       = r_sip;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_byte  = arpr_pkg::reply_byte(arpr_pkg::KIDX_W'(r_k), r_smac, r_sip,
                                               i_own_mac, i_own_ip);
            n_out_last  = r_k == K_LAST;
            n_k         = r_k + 1'b1;
            if (r_k == K_LAST) begin
                n_active = 1'b0;
            end
        end
        if (i_req.valid) begin
            n_active = 1'b1;
            n_k      = '0;
            n_smac   = i_req.sender_mac;
            n_sip    = i_req.sender_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_smac     <= n_smac;
        r_sip      <= n_sip;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_busy  = r_active;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    a_req_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> !r_active)
        else $error("reply requested while a reply is in progress");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_k <= K_LAST)
        else $error("reply byte counter out of range");

endmodule

// ===== design/arp_request_responder.sv =====
// Top level of the ARP request responder.
// Takes one received Ethernet frame byte per beat and answers an ARP request for the
// configured IPv4 address with a REPLY_LEN-byte zero-padded ARP reply, one byte per beat.
// Input beats are taken every cycle unless stalled; the answer is decided in the cycle
// after the last beat, and reply bytes leave at one per cycle unless held, through a
// registered output stage. One reply sequencer sends one reply at a time: when a second
// frame qualifies during a reply, input stalls until that reply's last byte is in the
// output register. Write own_ip and own_mac only while no frame or reply is in flight.
module arp_request_responder #(
    parameter int REPLY_LEN = arpr_pkg::REPLY_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] in_byte
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,   // [7:0] out_byte
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [arpr_pkg::CFG_W-1:0]    i_cfg_wdata
);

    logic [arpr_pkg::IP_W-1:0]  r_own_ip;
    logic [arpr_pkg::MAC_W-1:0] r_own_mac;
    arpr_pkg::t_reply_req       req;
    logic                       gen_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (arpr_pkg::t_cfg_reg'(i_cfg_addr))
                arpr_pkg::CFG_OWN_IP:  r_own_ip  <= i_cfg_wdata[arpr_pkg::IP_W-1:0];
                arpr_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_wdata[arpr_pkg::MAC_W-1:0];
                default: ;
            endcase
        end
    end

    arpr_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_own_ip   (r_own_ip),
        .i_gen_busy (gen_busy),
        .o_req      (req)
    );

    arpr_reply #(
        .REPLY_LEN (REPLY_LEN)
    ) u_reply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_own_mac (r_own_mac),
        .i_own_ip  (r_own_ip),
        .o_busy    (gen_busy),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule
